/* hw/rtl/point_in_polygon_crossing_core_macros.svh */
// assertion macros for the point-in-polygon crossing core
// needs a clock i_clk and an active-low reset i_rst_n in the using scope
`ifndef POINT_IN_POLYGON_CROSSING_CORE_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_CORE_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define PIPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PIPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pipc_pkg.sv */
// shared types and constants for the point-in-polygon crossing core
// no dependencies
package pipc_pkg;

    // coordinate width and derived arithmetic widths
    localparam int COORD_BITS    = 16;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = 2 * DIFF_BITS;
    localparam int SEEN_BITS     = 2;
    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 8;

    // minimum vertex count of a real polygon, also the saturation point
    localparam logic [SEEN_BITS-1:0] MIN_VERTICES = SEEN_BITS'(3);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // one vertex beat as held in the input register
    typedef struct packed {
        t_coord vx;
        t_coord vy;
        t_coord qx;
        t_coord qy;
        logic   first;
        logic   last;
    } t_item;

    // one result beat
    typedef struct packed {
        logic inside_res;
        logic too_few;
    } t_result;

endpackage

/* hw/rtl/point_in_polygon_crossing_core.sv */
// point-in-polygon crossing core: one vertex beat accepted per cycle unless a closing beat is held by a stalled output
// a result is written to the output register when its last vertex beat advances out of the input register
// throughput: one vertex per cycle, set by the parity update through the edge multipliers
// a stalled output holds back only closing beats and the beats queued behind them; other vertices keep flowing
// reset (synchronous, active low) clears beat valids and all polygon state to zero
// depends on pipc_pkg, pipc_poly, pipc_edge and the assertion macro header
module point_in_polygon_crossing_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // vertex_x, vertex_y, query_x, query_y
    input  logic [pipc_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,
    // first_vertex
    input  logic                                i_s_axis_tuser,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // inside_res, zero fill
    output logic [pipc_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    // too_few_vertices
    output logic                                o_m_axis_tuser
);
    import pipc_pkg::*;
    `include "point_in_polygon_crossing_core_macros.svh"

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;

    t_item   n_in;
    logic    n_in_valid;
    logic    n_out_valid;
    t_result w_res;
    logic    w_out_free;
    logic    w_adv;
    logic    w_in_acc;

    // handshake
    assign w_out_free      = !r_out_valid | i_m_axis_tready;
    assign w_adv           = r_in_valid & (!r_in.last | w_out_free);
    assign o_s_axis_tready = !r_in_valid | w_adv;
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;

    // unpack the input beat
    always_comb begin
        n_in.vx    = i_s_axis_tdata[COORD_BITS-1:0];
        n_in.vy    = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        n_in.qx    = i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
        n_in.qy    = i_s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
        n_in.first = i_s_axis_tuser;
        n_in.last  = i_s_axis_tlast;
    end

    // valid flags of both registers
    always_comb begin
        n_in_valid  = w_in_acc ? 1'b1 : (w_adv ? 1'b0 : r_in_valid);
        n_out_valid = (w_adv & r_in.last) ? 1'b1 :
                      (i_m_axis_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= n_in;
        end
        if (w_adv & r_in.last) begin
            r_out <= w_res;
        end
    end

    // polygon state and edge tests
    pipc_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    // output beat
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_BITS-1){1'b0}}, r_out.inside_res};
    assign o_m_axis_tuser  = r_out.too_few;

    // checks
    `PIPC_ASSERT_NOW(a_too_few_outside, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[0] == 1'b0, "inside flagged on a polygon with too few vertices")
    `PIPC_ASSERT_NOW(a_held_blocks_input, r_in_valid && !w_adv, !o_s_axis_tready, "input taken while the held vertex is stalled")
    `PIPC_ASSERT_NEXT(a_close_gives_result, w_adv && r_in.last, o_m_axis_tvalid, "closing vertex advanced without a result")

endmodule

/* hw/rtl/pipc_edge.sv */
// exact edge crossing test by signed cross-multiplication
// depends on pipc_pkg
module pipc_edge (
    input  pipc_pkg::t_coord i_xi,
    input  pipc_pkg::t_coord i_yi,
    input  pipc_pkg::t_coord i_xj,
    input  pipc_pkg::t_coord i_yj,
    input  pipc_pkg::t_coord i_qx,
    input  pipc_pkg::t_coord i_qy,
    output logic             o_toggle
);
    import pipc_pkg::*;

    logic signed [DIFF_BITS-1:0] w_dy;
    logic signed [DIFF_BITS-1:0] w_dqx;
    logic signed [DIFF_BITS-1:0] w_dx;
    logic signed [DIFF_BITS-1:0] w_dqy;
    logic signed [PROD_BITS-1:0] w_lhs;
    logic signed [PROD_BITS-1:0] w_rhs;
    logic                        w_straddle;

    // edge spans the query y on exactly one side
    assign w_straddle = (i_yi > i_qy) != (i_yj > i_qy);

    // sign-extended differences
    assign w_dy  = $signed({i_yj[COORD_BITS-1], i_yj}) - $signed({i_yi[COORD_BITS-1], i_yi});
    assign w_dqx = $signed({i_qx[COORD_BITS-1], i_qx}) - $signed({i_xi[COORD_BITS-1], i_xi});
    assign w_dx  = $signed({i_xj[COORD_BITS-1], i_xj}) - $signed({i_xi[COORD_BITS-1], i_xi});
    assign w_dqy = $signed({i_qy[COORD_BITS-1], i_qy}) - $signed({i_yi[COORD_BITS-1], i_yi});

    // two independent products, full width
    assign w_lhs = PROD_BITS'(w_dqx) * PROD_BITS'(w_dy);
    assign w_rhs = PROD_BITS'(w_dx) * PROD_BITS'(w_dqy);

    // crossing right of the query, compare direction follows the sign of dy
    assign o_toggle = w_straddle &
                      (w_dy[DIFF_BITS-1] ? (w_lhs > w_rhs) : (w_lhs < w_rhs));

endmodule

/* hw/rtl/pipc_poly.sv */
// polygon state: first and previous vertex, query point, parity, vertex count
// depends on pipc_pkg and pipc_edge
module pipc_poly (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  pipc_pkg::t_item   i_item,
    output pipc_pkg::t_result o_res
);
    import pipc_pkg::*;

    t_coord               r_first_vx, r_first_vy;
    t_coord               r_prev_vx, r_prev_vy;
    t_coord               r_held_qx, r_held_qy;
    logic                 r_parity;
    logic [SEEN_BITS-1:0] r_seen;

    logic                 n_parity;
    logic [SEEN_BITS-1:0] n_seen;
    logic                 w_run_tgl;
    logic                 w_close_tgl;

    // edge from previous vertex to this one
    pipc_edge u_run_edge (
        .i_xi     (i_item.vx),
        .i_yi     (i_item.vy),
        .i_xj     (r_prev_vx),
        .i_yj     (r_prev_vy),
        .i_qx     (r_held_qx),
        .i_qy     (r_held_qy),
        .o_toggle (w_run_tgl)
    );

    // closing edge from this vertex back to the first
    pipc_edge u_close_edge (
        .i_xi     (r_first_vx),
        .i_yi     (r_first_vy),
        .i_xj     (i_item.vx),
        .i_yj     (i_item.vy),
        .i_qx     (r_held_qx),
        .i_qy     (r_held_qy),
        .o_toggle (w_close_tgl)
    );

    // next parity and saturating count
    always_comb begin
        if (i_item.first) begin
            n_parity = 1'b0;
            n_seen   = SEEN_BITS'(1);
        end else begin
            n_parity = r_parity ^ w_run_tgl;
            n_seen   = (r_seen == MIN_VERTICES) ? r_seen : r_seen + SEEN_BITS'(1);
        end
    end

    // result for a closing beat
    always_comb begin
        o_res.too_few    = (n_seen < MIN_VERTICES);
        o_res.inside_res = !o_res.too_few & (n_parity ^ w_close_tgl);
    end

    // state update per vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_vx <= '0;
            r_first_vy <= '0;
            r_prev_vx  <= '0;
            r_prev_vy  <= '0;
            r_held_qx  <= '0;
            r_held_qy  <= '0;
            r_parity   <= 1'b0;
            r_seen     <= '0;
        end else if (i_adv) begin
            if (i_item.first) begin
                r_first_vx <= i_item.vx;
                r_first_vy <= i_item.vy;
                r_held_qx  <= i_item.qx;
                r_held_qy  <= i_item.qy;
            end
            r_prev_vx <= i_item.vx;
            r_prev_vy <= i_item.vy;
            r_parity  <= n_parity;
            r_seen    <= n_seen;
        end
    end

endmodule

/* dv/point_in_polygon_crossing_core_tb.sv */
// self-checking testbench for the point-in-polygon crossing core
// streams vertex beats, predicts the even-odd inside flag per closed polygon
// depends on pipc_pkg and point_in_polygon_crossing_core
`timescale 1ns / 100ps

module point_in_polygon_crossing_core_tb;

    import pipc_pkg::*;

    localparam int STIM_TARGET = 500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;
    localparam int CALM_TAIL   = 40;

    // geometry modes for random polygons
    typedef enum int {
        SPAN_TIGHT,
        SPAN_MID,
        SPAN_FULL
    } t_span;

    // one queued entry: a vertex beat, or a hold that waits for all verdicts
    typedef struct {
        t_item beat;
        bit    hold;
    } t_vertex_entry;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    // vertex_x, vertex_y, query_x, query_y
    logic [IN_DATA_BITS-1:0]   i_s_axis_tdata  = '0;
    // first_vertex
    logic                      i_s_axis_tuser  = 1'b0;
    logic                      i_s_axis_tlast  = 1'b0;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    // inside_res, zero fill
    logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata;
    // too_few_vertices
    logic                      o_m_axis_tuser;

    t_vertex_entry vertex_q[$];
    t_result       verdict_q[$];

    // predicted polygon state
    t_coord           anchor_x, anchor_y;
    t_coord           trail_x, trail_y;
    t_coord           probe_x, probe_y;
    bit               odd_crossings;
    logic [SEEN_BITS-1:0] vertex_tally;

    int  cycle_count = 0;
    int  fail_count  = 0;
    int  stim_count  = 0;
    int  gap_left    = 0;
    int  stall_left  = 0;
    bit  beat_taken  = 1'b0;
    bit  calm        = 1'b0;

    point_in_polygon_crossing_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // exact crossing test of edge (xi,yi)-(xj,yj) against the held query point
    function automatic bit crossing_flip(t_coord xi, t_coord yi, t_coord xj, t_coord yj);
        longint dy, lhs, rhs;
        if ((yi > probe_y) == (yj > probe_y))
            return 1'b0;
        dy  = longint'(yj) - longint'(yi);
        lhs = (longint'(probe_x) - longint'(xi)) * dy;
        rhs = (longint'(xj) - longint'(xi)) * (longint'(probe_y) - longint'(yi));
        return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    // advance the predicted state by one accepted vertex beat
    task automatic absorb_vertex(t_item beat);
        t_result verdict;
        if (beat.first) begin
            probe_x       = beat.qx;
            probe_y       = beat.qy;
            anchor_x      = beat.vx;
            anchor_y      = beat.vy;
            odd_crossings = 1'b0;
            vertex_tally  = SEEN_BITS'(1);
        end else begin
            odd_crossings ^= crossing_flip(beat.vx, beat.vy, trail_x, trail_y);
            if (vertex_tally < MIN_VERTICES)
                vertex_tally++;
        end
        trail_x = beat.vx;
        trail_y = beat.vy;
        if (beat.last) begin
            if (vertex_tally < MIN_VERTICES) begin
                verdict.inside_res = 1'b0;
                verdict.too_few    = 1'b1;
            end else begin
                verdict.inside_res = odd_crossings
                                   ^ crossing_flip(anchor_x, anchor_y, beat.vx, beat.vy);
                verdict.too_few    = 1'b0;
            end
            verdict_q.push_back(verdict);
        end
    endtask

    task automatic queue_vertex(int vx, int vy, int qx, int qy, bit first, bit last);
        t_vertex_entry entry;
        entry.beat.vx    = t_coord'(vx);
        entry.beat.vy    = t_coord'(vy);
        entry.beat.qx    = t_coord'(qx);
        entry.beat.qy    = t_coord'(qy);
        entry.beat.first = first;
        entry.beat.last  = last;
        entry.hold       = 1'b0;
        vertex_q.push_back(entry);
        stim_count++;
    endtask

    task automatic queue_hold();
        t_vertex_entry entry;
        entry.beat = '0;
        entry.hold = 1'b1;
        vertex_q.push_back(entry);
    endtask

    // coordinate around a cluster center, or anywhere with extremes favored
    function automatic int pick_coord(t_span span, int center);
        int corner;
        case (span)
            SPAN_TIGHT: return center + int'($urandom_range(0, 16)) - 8;
            SPAN_MID:   return center + int'($urandom_range(0, 2000)) - 1000;
            default: begin
                corner = $urandom_range(0, 7);
                if (corner == 0)
                    return $urandom_range(0, 1) ? -32768 : 32767;
                return int'(t_coord'($urandom()));
            end
        endcase
    endfunction

    // random polygon of n vertices, query in the same cluster
    task automatic queue_polygon(int n, bit close_it);
        t_span span;
        int    pick, cx, cy, qx, qy;
        pick = $urandom_range(0, 9);
        span = (pick < 6) ? SPAN_TIGHT : (pick < 9) ? SPAN_MID : SPAN_FULL;
        cx   = int'($urandom_range(0, 60000)) - 30000;
        cy   = int'($urandom_range(0, 60000)) - 30000;
        qx   = pick_coord(span, cx);
        qy   = pick_coord(span, cy);
        for (int k = 0; k < n; k++) begin
            // query fields on later vertices carry ignored noise
            queue_vertex(pick_coord(span, cx), pick_coord(span, cy),
                         (k == 0) ? qx : int'($urandom()), (k == 0) ? qy : int'($urandom()),
                         k == 0, close_it && (k == n - 1));
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        int pick, extra;
        bit hold_done;
        hold_done = 1'b0;

        // vertices before any first vertex continue a zeroed polygon
        queue_vertex(10, -10, 3, 3, 1'b0, 1'b0);
        queue_vertex(0, 10, -3, 7, 1'b0, 1'b0);
        queue_vertex(-10, -10, 1, 1, 1'b0, 1'b1);
        // single vertex polygon
        queue_vertex(4, 4, 4, 4, 1'b1, 1'b1);
        // two vertex polygon
        queue_vertex(-5, 0, 0, 0, 1'b1, 1'b0);
        queue_vertex(5, 0, 9, 9, 1'b0, 1'b1);
        // triangle around the query
        queue_vertex(-10, -10, 0, 0, 1'b1, 1'b0);
        queue_vertex(10, -10, 0, 0, 1'b0, 1'b0);
        queue_vertex(0, 10, 0, 0, 1'b0, 1'b1);
        // same triangle, query to the right
        queue_vertex(-10, -10, 20, 0, 1'b1, 1'b0);
        queue_vertex(10, -10, 0, 0, 1'b0, 1'b0);
        queue_vertex(0, 10, 0, 0, 1'b0, 1'b1);
        // query y level with a vertex
        queue_vertex(0, 0, -5, 0, 1'b1, 1'b0);
        queue_vertex(10, 5, 0, 0, 1'b0, 1'b0);
        queue_vertex(10, -5, 0, 0, 1'b0, 1'b1);
        // full-range square, then extended past its last vertex
        queue_vertex(-32768, -32768, 0, 0, 1'b1, 1'b0);
        queue_vertex(32767, -32768, -1, -1, 1'b0, 1'b0);
        queue_vertex(32767, 32767, 32767, 32767, 1'b0, 1'b0);
        queue_vertex(-32768, 32767, -32768, -32768, 1'b0, 1'b1);
        queue_vertex(0, -32768, 0, 0, 1'b0, 1'b1);
        // extreme query corner
        queue_vertex(-32768, 32767, -32768, -32768, 1'b1, 1'b0);
        queue_vertex(32767, -32768, 0, 0, 1'b0, 1'b0);
        queue_vertex(32767, 32767, 0, 0, 1'b0, 1'b1);
        queue_hold();

        // random polygons, with stray, short and unclosed sequences mixed in
        while (stim_count < STIM_TARGET + 23) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                queue_vertex(int'(t_coord'($urandom())), int'(t_coord'($urandom())),
                             int'($urandom()), int'($urandom()), 1'b0, $urandom_range(0, 1));
            end else if (pick < 14) begin
                queue_polygon($urandom_range(1, 2), 1'b1);
            end else if (pick < 20) begin
                // closed early, then more vertices and a second close
                queue_polygon($urandom_range(3, 6), 1'b1);
                extra = $urandom_range(1, 3);
                for (int k = 0; k < extra; k++)
                    queue_vertex(pick_coord(SPAN_MID, 0), pick_coord(SPAN_MID, 0),
                                 int'($urandom()), int'($urandom()), 1'b0, k == extra - 1);
            end else if (pick < 24) begin
                queue_polygon($urandom_range(2, 6), 1'b0);
            end else begin
                queue_polygon($urandom_range(3, 9), 1'b1);
            end
            if (!hold_done && stim_count > STIM_TARGET / 2) begin
                queue_hold();
                hold_done = 1'b1;
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (vertex_q.size() != 0 || i_s_axis_tvalid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && verdict_q.size() == 0)
            $display("point_in_polygon_crossing_core_tb: done, clean");
        else
            $display("point_in_polygon_crossing_core_tb: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("point_in_polygon_crossing_core_tb: done, errors");
        $finish;
    end

    // accept beats into the predictor and check result beats
    always @(posedge i_clk) begin
        cycle_count++;
        beat_taken = 1'b0;
        // idling off near the end and whenever bits 9:8 of the cycle count are both set
        calm = (vertex_q.size() < CALM_TAIL) || (((cycle_count >> 8) % 4) == 3);
        if (!i_rst_n) begin
            anchor_x      = '0;
            anchor_y      = '0;
            trail_x       = '0;
            trail_y       = '0;
            probe_x       = '0;
            probe_y       = '0;
            odd_crossings = 1'b0;
            vertex_tally  = '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                absorb_vertex(vertex_q[0].beat);
                void'(vertex_q.pop_front());
                beat_taken = 1'b1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result beat with none expected: inside %0b too_few %0b",
                             $time, o_m_axis_tdata[0], o_m_axis_tuser);
                    fail_count++;
                end else begin
                    if (o_m_axis_tdata[0] !== verdict_q[0].inside_res) begin
                        $display("%0t: inside mismatch: expected %0b actual %0b",
                                 $time, verdict_q[0].inside_res, o_m_axis_tdata[0]);
                        fail_count++;
                    end
                    if (o_m_axis_tuser !== verdict_q[0].too_few) begin
                        $display("%0t: too_few mismatch: expected %0b actual %0b",
                                 $time, verdict_q[0].too_few, o_m_axis_tuser);
                        fail_count++;
                    end
                    void'(verdict_q.pop_front());
                end
            end
        end
    end

    // vertex driver: holds a beat until taken, random gaps between beats
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_s_axis_tvalid && !beat_taken)) begin
            // a hold entry stalls the stream until every verdict has arrived
            while (vertex_q.size() != 0 && vertex_q[0].hold && verdict_q.size() == 0)
                void'(vertex_q.pop_front());
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (vertex_q.size() != 0 && !vertex_q[0].hold) begin
                if (!calm && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 9) - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {vertex_q[0].beat.qy, vertex_q[0].beat.qx,
                                        vertex_q[0].beat.vy, vertex_q[0].beat.vx};
                    i_s_axis_tuser  <= vertex_q[0].beat.first;
                    i_s_axis_tlast  <= vertex_q[0].beat.last;
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink: random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

endmodule
